/* hw/rtl/pidc_pkg.sv */
`default_nettype none
package pidc_pkg;

   localparam int VALUE_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int INTEG_BITS = 48;
   localparam int GAIN_BITS = 31;
   localparam int EVAL_BITS = 16;
   localparam int CSR_INDEX_BITS = 3;

   // Shared multiply / divide unit sizes.
   localparam int MD_A_BITS = 64;
   localparam int MD_B_BITS = 48;
   localparam int MD_R_BITS = 96;
   localparam int MUL_STEPS = 32;
   localparam int DIV_STEPS = 64;
   localparam int MD_CNT_BITS = 6;

   localparam logic [63:0] MAG_CLAMP = 64'h4000_0000_0000_0000;
   localparam logic [VALUE_BITS-1:0] SETPOINT_RESET = 32'd1441792;
   localparam logic [GAIN_BITS-1:0] GAIN_ONE = 31'd65536;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_START = 2'd1,
      KIND_STOP  = 2'd2,
      KIND_LOAD  = 2'd3
   } kind_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_KP     = 3'd0,
      CSR_TI     = 3'd1,
      CSR_TD     = 3'd2,
      CSR_OUT_HI = 3'd3,
      CSR_OUT_LO = 3'd4,
      CSR_EVALS  = 3'd5
   } csr_index_type;

   typedef enum logic {
      MD_MUL = 1'b0,
      MD_DIV = 1'b1
   } md_op_type;

   typedef struct packed {
      logic      start;
      md_op_type op;
   } md_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } md_sts_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_INTEG_MUL,
      ST_INTEG_ADD,
      ST_ITERM_DIV,
      ST_DERIV_MUL,
      ST_DERIV_DIV,
      ST_SUM,
      ST_DRIVE_MUL,
      ST_OUT,
      ST_START_MUL,
      ST_START_DIV
   } state_type;

endpackage
`default_nettype wire

/* hw/rtl/pidc_req_if.sv */
`default_nettype none
interface pidc_req_if import pidc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            kind;
   logic [31:0]           time_now;
   logic [VALUE_BITS-1:0] measured;
   logic [VALUE_BITS-1:0] drive_now;
   logic [VALUE_BITS-1:0] target;

   modport source (output valid, kind, time_now, measured, drive_now, target, input ready);
   modport sink (input valid, kind, time_now, measured, drive_now, target, output ready);
endinterface
`default_nettype wire

/* hw/rtl/pidc_rsp_if.sv */
`default_nettype none
interface pidc_rsp_if import pidc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] drive;
   logic [VALUE_BITS-1:0] error_value;
   logic                  integrated;

   modport source (output valid, drive, error_value, integrated, input ready);
   modport sink (input valid, drive, error_value, integrated, output ready);
endinterface
`default_nettype wire

/* hw/rtl/pidc_muldiv.sv */
`default_nettype none
module pidc_muldiv import pidc_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire md_cmd_type           cmd,
   input  wire logic [MD_A_BITS-1:0] opa,
   input  wire logic [MD_B_BITS-1:0] opb,
   output md_sts_type                sts,
   output logic [MD_R_BITS-1:0]      result
);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   md_op_type              op_ff, op_in;
   logic [MD_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [MD_R_BITS-1:0]   acc_ff, acc_in;
   logic [MUL_STEPS-1:0]   mplr_ff, mplr_in;
   logic [MD_A_BITS-1:0]   mcand_ff, mcand_in;
   logic [MD_B_BITS-1:0]   dvsr_ff, dvsr_in;
   logic [MD_B_BITS-1:0]   rem_ff, rem_in;

   logic [MD_B_BITS:0]     rem_try;
   logic [MD_B_BITS:0]     rem_diff;
   logic                   fits;
   logic [MD_R_BITS-1:0]   addend;

   // Multiply goes MSB first over the multiplier; divide is restoring, with the
   // quotient shifting into the low word of the accumulator.
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      op_in    = op_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      mplr_in  = mplr_ff;
      mcand_in = mcand_ff;
      dvsr_in  = dvsr_ff;
      rem_in   = rem_ff;

      rem_try  = {rem_ff, acc_ff[MD_A_BITS-1]};
      rem_diff = rem_try - {1'b0, dvsr_ff};
      fits     = rem_try >= {1'b0, dvsr_ff};
      addend   = mplr_ff[MUL_STEPS-1] ? {{(MD_R_BITS-MD_A_BITS){1'b0}}, mcand_ff} : '0;

      if (cmd.start) begin
         busy_in  = 1'b1;
         op_in    = cmd.op;
         mcand_in = opa;
         mplr_in  = opb[MUL_STEPS-1:0];
         dvsr_in  = opb;
         rem_in   = '0;
         if (cmd.op == MD_MUL) begin
            acc_in = '0;
            cnt_in = MD_CNT_BITS'(MUL_STEPS - 1);
         end else begin
            acc_in = {{(MD_R_BITS-MD_A_BITS){1'b0}}, opa};
            cnt_in = MD_CNT_BITS'(DIV_STEPS - 1);
         end
      end else if (busy_ff) begin
         if (op_ff == MD_MUL) begin
            acc_in  = {acc_ff[MD_R_BITS-2:0], 1'b0} + addend;
            mplr_in = {mplr_ff[MUL_STEPS-2:0], 1'b0};
         end else begin
            rem_in = fits ? rem_diff[MD_B_BITS-1:0] : rem_try[MD_B_BITS-1:0];
            acc_in = {{(MD_R_BITS-MD_A_BITS){1'b0}}, acc_ff[MD_A_BITS-2:0], fits};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      cnt_ff   <= cnt_in;
      acc_ff   <= acc_in;
      mplr_ff  <= mplr_in;
      mcand_ff <= mcand_in;
      dvsr_ff  <= dvsr_in;
      rem_ff   <= rem_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign result   = acc_ff;

endmodule
`default_nettype wire

/* hw/rtl/pid_controller_trapezoid_antiwindup.sv */
// A loop evaluation holds the input until it is done; it uses up to two 32-step multiplies,
// two 64-step divides and one more multiply, all in the one shared multiply / divide unit.
// The derivative multiply and divide are skipped when the time step is zero, and the
// integral multiply as well when integration is held.
// A start (or a setpoint load while stopped) runs a multiply and a divide; a stop, or a load while running, does not.
// Throughput is one item at a time; a finished result waits in an output register.
// Reset is synchronous, active high, and restores the configuration, control and loop-state registers.
`default_nettype none
module pid_controller_trapezoid_antiwindup import pidc_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   pidc_req_if.sink                       req,
   pidc_rsp_if.source                     rsp,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [VALUE_BITS-1:0]     csr_wdata
);

   state_type                     state_ff, state_in;
   logic                          op_started_ff, op_started_in;

   logic [GAIN_BITS-1:0]          kp_ff, kp_in, ti_ff, ti_in, td_ff, td_in;
   logic signed [VALUE_BITS-1:0]  out_hi_ff, out_hi_in, out_lo_ff, out_lo_in;
   logic [EVAL_BITS-1:0]          evals_ff, evals_in;

   logic                          enabled_ff, enabled_in;
   logic [VALUE_BITS-1:0]         setpoint_ff, setpoint_in;
   logic [INTEG_BITS-1:0]         integral_ff, integral_in;
   logic [31:0]                   prev_time_ff, prev_time_in;
   logic [VALUE_BITS-1:0]         prev_error_ff, prev_error_in;
   logic [VALUE_BITS-1:0]         prev_meas_ff, prev_meas_in;
   logic signed [VALUE_BITS-1:0]  prev_drive_ff, prev_drive_in;
   logic [EVAL_BITS-1:0]          countdown_ff, countdown_in;

   kind_type                      kind_ff, kind_in;
   logic [31:0]                   time_ff, time_in;
   logic [VALUE_BITS-1:0]         meas_ff, meas_in, drvn_ff, drvn_in, target_ff, target_in;

   logic [31:0]                   dt_ff, dt_in;
   logic [VALUE_BITS-1:0]         err_ff, err_in;
   logic                          integ_ff, integ_in;
   logic                          sum_neg_ff, sum_neg_in;
   logic [VALUE_BITS:0]           sum_mag_ff, sum_mag_in;
   logic                          dm_neg_ff, dm_neg_in;
   logic [VALUE_BITS:0]           dm_mag_ff, dm_mag_in;
   logic [63:0]                   iterm_ff, iterm_in, dterm_ff, dterm_in;
   logic                          s_neg_ff, s_neg_in;
   logic [62:0]                   s_mag_ff, s_mag_in;
   logic [VALUE_BITS-1:0]         new_drive_ff, new_drive_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0]         rsp_drive_ff, rsp_drive_in, rsp_err_ff, rsp_err_in;
   logic                          rsp_integ_ff, rsp_integ_in;

   md_cmd_type                    md_cmd;
   md_sts_type                    md_sts;
   logic [MD_A_BITS-1:0]          md_opa;
   logic [MD_B_BITS-1:0]          md_opb;
   logic [MD_R_BITS-1:0]          md_result;

   logic [GAIN_BITS-1:0]          kp_nz, ti_nz;
   logic [EVAL_BITS-1:0]          evals_m1;
   logic [VALUE_BITS:0]           diff33, sum33, dm33;
   logic [VALUE_BITS-1:0]         err_c;
   logic [63:0]                   prod_p, half_p, step_c, total_c, s_c;
   logic [INTEG_BITS-1:0]         imag_c;
   logic [VALUE_BITS-1:0]         dmag_c;
   logic [78:0]                   drive_q;
   logic [63:0]                   quo;

   function automatic logic [63:0] clamp_signed(input logic neg, input logic [63:0] m);
      logic [63:0] c;
      c = (m > MAG_CLAMP) ? MAG_CLAMP : m;
      return neg ? (~c + 64'd1) : c;
   endfunction

   pidc_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .cmd    (md_cmd),
      .opa    (md_opa),
      .opb    (md_opb),
      .sts    (md_sts),
      .result (md_result)
   );

   assign kp_nz    = (kp_ff == '0) ? GAIN_BITS'(1) : kp_ff;
   assign ti_nz    = (ti_ff == '0) ? GAIN_BITS'(1) : ti_ff;
   assign evals_m1 = (evals_ff == '0) ? '0 : evals_ff - 1'b1;
   assign quo      = md_result[63:0];

   // Evaluation front end: saturated error, error sum and measurement step.
   always_comb begin
      diff33 = {setpoint_ff[VALUE_BITS-1], setpoint_ff} - {meas_ff[VALUE_BITS-1], meas_ff};
      if (diff33[VALUE_BITS] != diff33[VALUE_BITS-1]) begin
         err_c = diff33[VALUE_BITS] ? {1'b1, {(VALUE_BITS-1){1'b0}}}
                                    : {1'b0, {(VALUE_BITS-1){1'b1}}};
      end else begin
         err_c = diff33[VALUE_BITS-1:0];
      end
      sum33 = {prev_error_ff[VALUE_BITS-1], prev_error_ff} + {err_c[VALUE_BITS-1], err_c};
      dm33  = {meas_ff[VALUE_BITS-1], meas_ff} - {prev_meas_ff[VALUE_BITS-1], prev_meas_ff};
   end

   // Trapezoid step: floor of half the product, then a 48-bit saturating add.
   always_comb begin
      prod_p  = md_result[63:0];
      half_p  = {1'b0, prod_p[63:1]} + {63'd0, sum_neg_ff & prod_p[0]};
      step_c  = clamp_signed(sum_neg_ff, half_p);
      total_c = {{(64-INTEG_BITS){integral_ff[INTEG_BITS-1]}}, integral_ff} + step_c;
      imag_c  = integral_ff[INTEG_BITS-1] ? (~integral_ff + 1'b1) : integral_ff;
      dmag_c  = drvn_ff[VALUE_BITS-1] ? (~drvn_ff + 1'b1) : drvn_ff;
      s_c     = {{(64-VALUE_BITS){err_ff[VALUE_BITS-1]}}, err_ff} + iterm_ff - dterm_ff;
      drive_q = md_result[94:FRAC_BITS];
   end

   always_comb begin
      state_in      = state_ff;
      op_started_in = op_started_ff;
      kp_in         = kp_ff;
      ti_in         = ti_ff;
      td_in         = td_ff;
      out_hi_in     = out_hi_ff;
      out_lo_in     = out_lo_ff;
      evals_in      = evals_ff;
      enabled_in    = enabled_ff;
      setpoint_in   = setpoint_ff;
      integral_in   = integral_ff;
      prev_time_in  = prev_time_ff;
      prev_error_in = prev_error_ff;
      prev_meas_in  = prev_meas_ff;
      prev_drive_in = prev_drive_ff;
      countdown_in  = countdown_ff;
      kind_in       = kind_ff;
      time_in       = time_ff;
      meas_in       = meas_ff;
      drvn_in       = drvn_ff;
      target_in     = target_ff;
      dt_in         = dt_ff;
      err_in        = err_ff;
      integ_in      = integ_ff;
      sum_neg_in    = sum_neg_ff;
      sum_mag_in    = sum_mag_ff;
      dm_neg_in     = dm_neg_ff;
      dm_mag_in     = dm_mag_ff;
      iterm_in      = iterm_ff;
      dterm_in      = dterm_ff;
      s_neg_in      = s_neg_ff;
      s_mag_in      = s_mag_ff;
      new_drive_in  = new_drive_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_drive_in  = rsp_drive_ff;
      rsp_err_in    = rsp_err_ff;
      rsp_integ_in  = rsp_integ_ff;
      md_cmd.start  = 1'b0;
      md_cmd.op     = MD_MUL;
      md_opa        = '0;
      md_opb        = '0;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_KP:     kp_in = csr_wdata[GAIN_BITS-1:0];
            CSR_TI:     ti_in = csr_wdata[GAIN_BITS-1:0];
            CSR_TD:     td_in = csr_wdata[GAIN_BITS-1:0];
            CSR_OUT_HI: out_hi_in = csr_wdata;
            CSR_OUT_LO: out_lo_in = csr_wdata;
            CSR_EVALS:  evals_in = csr_wdata[EVAL_BITS-1:0];
            default: ;
         endcase
      end

      // Operation states issue once, then wait for the unit to finish.
      if (state_ff inside {ST_INTEG_MUL, ST_ITERM_DIV, ST_DERIV_MUL, ST_DERIV_DIV,
                           ST_DRIVE_MUL, ST_START_MUL, ST_START_DIV}) begin
         md_cmd.start = !op_started_ff;
         if (!op_started_ff) begin
            op_started_in = 1'b1;
         end else if (md_sts.done) begin
            op_started_in = 1'b0;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               kind_in   = kind_type'(req.kind);
               time_in   = req.time_now;
               meas_in   = req.measured;
               drvn_in   = req.drive_now;
               target_in = req.target;
               case (kind_type'(req.kind))
                  KIND_TICK: begin
                     if (enabled_ff) begin
                        if (countdown_ff != '0) begin
                           countdown_in = countdown_ff - 1'b1;
                        end else begin
                           countdown_in = evals_m1;
                           state_in     = ST_PREP;
                        end
                     end
                  end
                  KIND_START: state_in = ST_START_MUL;
                  KIND_STOP:  enabled_in = 1'b0;
                  KIND_LOAD: begin
                     if (enabled_ff) begin
                        setpoint_in = req.target;
                     end else begin
                        state_in = ST_START_MUL;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_PREP: begin
            dt_in      = time_ff - prev_time_ff;
            err_in     = err_c;
            integ_in   = (prev_drive_ff < out_hi_ff) && (prev_drive_ff > out_lo_ff);
            sum_neg_in = sum33[VALUE_BITS];
            sum_mag_in = sum33[VALUE_BITS] ? (~sum33 + 1'b1) : sum33;
            dm_neg_in  = dm33[VALUE_BITS];
            dm_mag_in  = dm33[VALUE_BITS] ? (~dm33 + 1'b1) : dm33;
            state_in   = ((prev_drive_ff < out_hi_ff) && (prev_drive_ff > out_lo_ff))
                         ? ST_INTEG_MUL : ST_ITERM_DIV;
         end
         ST_INTEG_MUL: begin
            md_cmd.op = MD_MUL;
            md_opa    = {{(MD_A_BITS-VALUE_BITS-1){1'b0}}, sum_mag_ff};
            md_opb    = {{(MD_B_BITS-32){1'b0}}, dt_ff};
            if (op_started_ff && md_sts.done) begin
               state_in = ST_INTEG_ADD;
            end
         end
         ST_INTEG_ADD: begin
            if (total_c[63:INTEG_BITS-1] == '0 || total_c[63:INTEG_BITS-1] == '1) begin
               integral_in = total_c[INTEG_BITS-1:0];
            end else begin
               integral_in = total_c[63] ? {1'b1, {(INTEG_BITS-1){1'b0}}}
                                         : {1'b0, {(INTEG_BITS-1){1'b1}}};
            end
            state_in = ST_ITERM_DIV;
         end
         ST_ITERM_DIV: begin
            md_cmd.op = MD_DIV;
            md_opa    = {imag_c, {FRAC_BITS{1'b0}}};
            md_opb    = {{(MD_B_BITS-GAIN_BITS){1'b0}}, ti_nz};
            if (op_started_ff && md_sts.done) begin
               iterm_in = clamp_signed(integral_ff[INTEG_BITS-1], quo);
               if (dt_ff != '0) begin
                  state_in = ST_DERIV_MUL;
               end else begin
                  dterm_in = '0;
                  state_in = ST_SUM;
               end
            end
         end
         ST_DERIV_MUL: begin
            md_cmd.op = MD_MUL;
            md_opa    = {{(MD_A_BITS-VALUE_BITS-1){1'b0}}, dm_mag_ff};
            md_opb    = {{(MD_B_BITS-GAIN_BITS){1'b0}}, td_ff};
            if (op_started_ff && md_sts.done) begin
               state_in = ST_DERIV_DIV;
            end
         end
         ST_DERIV_DIV: begin
            md_cmd.op = MD_DIV;
            md_opa    = md_result[MD_A_BITS-1:0];
            md_opb    = {dt_ff, {FRAC_BITS{1'b0}}};
            if (op_started_ff && md_sts.done) begin
               dterm_in = clamp_signed(dm_neg_ff, quo);
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            s_neg_in = s_c[63];
            s_mag_in = s_c[63] ? (~s_c[62:0] + 1'b1) : s_c[62:0];
            state_in = ST_DRIVE_MUL;
         end
         ST_DRIVE_MUL: begin
            md_cmd.op = MD_MUL;
            md_opa    = {1'b0, s_mag_ff};
            md_opb    = {{(MD_B_BITS-GAIN_BITS){1'b0}}, kp_nz};
            if (op_started_ff && md_sts.done) begin
               // Anything at or beyond 2^31 saturates for either sign.
               if (drive_q[78:VALUE_BITS-1] != '0) begin
                  new_drive_in = s_neg_ff ? {1'b1, {(VALUE_BITS-1){1'b0}}}
                                          : {1'b0, {(VALUE_BITS-1){1'b1}}};
               end else begin
                  new_drive_in = s_neg_ff ? (~drive_q[VALUE_BITS-1:0] + 1'b1)
                                          : drive_q[VALUE_BITS-1:0];
               end
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_drive_in  = new_drive_ff;
               rsp_err_in    = err_ff;
               rsp_integ_in  = integ_ff;
               prev_time_in  = time_ff;
               prev_meas_in  = meas_ff;
               prev_drive_in = new_drive_ff;
               prev_error_in = err_ff;
               state_in      = ST_IDLE;
            end
         end
         ST_START_MUL: begin
            md_cmd.op = MD_MUL;
            md_opa    = {{(MD_A_BITS-VALUE_BITS){1'b0}}, dmag_c};
            md_opb    = {{(MD_B_BITS-GAIN_BITS){1'b0}}, ti_nz};
            if (op_started_ff && md_sts.done) begin
               state_in = ST_START_DIV;
            end
         end
         ST_START_DIV: begin
            md_cmd.op = MD_DIV;
            md_opa    = md_result[MD_A_BITS-1:0];
            md_opb    = {{(MD_B_BITS-GAIN_BITS){1'b0}}, kp_nz};
            if (op_started_ff && md_sts.done) begin
               // Bumpless preload, saturated to the integral width.
               if (drvn_ff[VALUE_BITS-1]) begin
                  integral_in = (quo > {{(64-INTEG_BITS){1'b0}}, 1'b1, {(INTEG_BITS-1){1'b0}}})
                                ? {1'b1, {(INTEG_BITS-1){1'b0}}}
                                : (~quo[INTEG_BITS-1:0] + 1'b1);
               end else begin
                  integral_in = (quo[63:INTEG_BITS-1] != '0)
                                ? {1'b0, {(INTEG_BITS-1){1'b1}}} : quo[INTEG_BITS-1:0];
               end
               setpoint_in   = (kind_ff == KIND_LOAD) ? target_ff : meas_ff;
               prev_time_in  = time_ff;
               prev_error_in = '0;
               prev_drive_in = drvn_ff;
               prev_meas_in  = meas_ff;
               enabled_in    = 1'b1;
               countdown_in  = evals_m1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         op_started_ff <= 1'b0;
         kp_ff         <= GAIN_ONE;
         ti_ff         <= GAIN_ONE;
         td_ff         <= '0;
         out_hi_ff     <= {1'b0, {(VALUE_BITS-1){1'b1}}};
         out_lo_ff     <= {1'b1, {(VALUE_BITS-1){1'b0}}};
         evals_ff      <= EVAL_BITS'(1);
         enabled_ff    <= 1'b0;
         setpoint_ff   <= SETPOINT_RESET;
         integral_ff   <= '0;
         prev_time_ff  <= '0;
         prev_error_ff <= '0;
         prev_meas_ff  <= '0;
         prev_drive_ff <= '0;
         countdown_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         op_started_ff <= op_started_in;
         kp_ff         <= kp_in;
         ti_ff         <= ti_in;
         td_ff         <= td_in;
         out_hi_ff     <= out_hi_in;
         out_lo_ff     <= out_lo_in;
         evals_ff      <= evals_in;
         enabled_ff    <= enabled_in;
         setpoint_ff   <= setpoint_in;
         integral_ff   <= integral_in;
         prev_time_ff  <= prev_time_in;
         prev_error_ff <= prev_error_in;
         prev_meas_ff  <= prev_meas_in;
         prev_drive_ff <= prev_drive_in;
         countdown_ff  <= countdown_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      time_ff      <= time_in;
      meas_ff      <= meas_in;
      drvn_ff      <= drvn_in;
      target_ff    <= target_in;
      dt_ff        <= dt_in;
      err_ff       <= err_in;
      integ_ff     <= integ_in;
      sum_neg_ff   <= sum_neg_in;
      sum_mag_ff   <= sum_mag_in;
      dm_neg_ff    <= dm_neg_in;
      dm_mag_ff    <= dm_mag_in;
      iterm_ff     <= iterm_in;
      dterm_ff     <= dterm_in;
      s_neg_ff     <= s_neg_in;
      s_mag_ff     <= s_mag_in;
      new_drive_ff <= new_drive_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_integ_ff <= rsp_integ_in;
   end

   assign req.ready       = (state_ff == ST_IDLE);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.drive       = rsp_drive_ff;
   assign rsp.error_value = rsp_err_ff;
   assign rsp.integrated  = rsp_integ_ff;

   a_done_when_issued: assert property (@(posedge clock) disable iff (reset)
      md_sts.done |-> op_started_ff)
      else $error("arithmetic unit finished without an issued operation");

   a_idle_unit_free: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !md_sts.busy)
      else $error("item accepted while the arithmetic unit is busy");

   a_result_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside the output step");

endmodule
`default_nettype wire
